FILE: rtl/core/rdt_pkg.sv
`timescale 1ns / 1ps
// rdt_pkg: shared types, codes and constants for the delivery tracker.
// Used by rdt_ctrl, rdt_datapath and reliable_delivery_tracker; no dependencies.
package rdt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int ACK_DEPTH_DEF   = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int HIT_W           = $clog2(MAX_RESULTS + 1);
    localparam int SEQ_W           = 32;
    localparam int TIME_W          = 32;
    localparam int TIMEOUT_W       = 20;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd1000;

    typedef enum logic [2:0] {
        KIND_SEND  = 3'd0,
        KIND_RECV  = 3'd1,
        KIND_ACK   = 3'd2,
        KIND_SCAN  = 3'd3,
        KIND_FLUSH = 3'd4,
        KIND_CLEAR = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        EV_SENT          = 4'd0,
        EV_ACCEPTED      = 4'd1,
        EV_ACCEPTED_FULL = 4'd2,
        EV_REJECTED      = 4'd3,
        EV_DELIVERED     = 4'd4,
        EV_TIMED_OUT     = 4'd5,
        EV_ACK_OUT       = 4'd6,
        EV_NOTHING       = 4'd7,
        EV_TABLE_FULL    = 4'd8,
        EV_CLEARED       = 4'd9
    } event_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch the accepted item
        logic idx_inc;   // step the table index
        logic tbl_rd;    // read the table entry at the index
        logic hit_take;  // retire the matching entry, hold it as pending result
        logic tbl_end;   // emit pending result (or nothing) as last
        logic single;    // perform a one-result operation and emit it
        logic ack_rd;    // read the ack queue head
        logic ack_pop;   // emit the head ack and pop it
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  cur_valid;
        logic  idx_last;
        logic  hit;
        logic  hit_last;
        logic  pend_valid;
        logic  out_free;
        logic  rem_zero;
        logic  rem_one;
    } status_t;

endpackage

FILE: rtl/core/rdt_ctrl.sv
`timescale 1ns / 1ps
// rdt_ctrl: sequencing state machine of the delivery tracker.
// Depends on rdt_pkg; drives commands to rdt_datapath from its status.
module rdt_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rdt_pkg::status_t sts,
    output rdt_pkg::cmd_t    cmd
);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_DISPATCH  = 9'b000000010,
        ST_SEND_WALK = 9'b000000100,
        ST_SINGLE    = 9'b000001000,
        ST_TBL_RD    = 9'b000010000,
        ST_TBL_CHK   = 9'b000100000,
        ST_TBL_END   = 9'b001000000,
        ST_ACK_RD    = 9'b010000000,
        ST_ACK_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (sts.kind)
                    rdt_pkg::KIND_SEND:  state_next = ST_SEND_WALK;
                    rdt_pkg::KIND_ACK:   state_next = ST_TBL_RD;
                    rdt_pkg::KIND_SCAN:  state_next = ST_TBL_RD;
                    rdt_pkg::KIND_FLUSH: state_next = sts.rem_zero ? ST_SINGLE : ST_ACK_RD;
                    default:             state_next = ST_SINGLE;
                endcase
            end
            ST_SEND_WALK:
            begin
                // advance to the lowest free slot, or stop on the last one
                if (sts.cur_valid && !sts.idx_last)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else
                begin
                    state_next = ST_SINGLE;
                end
            end
            ST_SINGLE:
            begin
                if (sts.out_free)
                begin
                    cmd.single = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TBL_RD:
            begin
                if (sts.cur_valid)
                begin
                    cmd.tbl_rd = 1'b1;
                    state_next = ST_TBL_CHK;
                end
                else if (sts.idx_last)
                begin
                    state_next = ST_TBL_END;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_TBL_CHK:
            begin
                if (sts.hit)
                begin
                    // hold until the older pending result can move out
                    if (!sts.pend_valid || sts.out_free)
                    begin
                        cmd.hit_take = 1'b1;
                        if (sts.hit_last || sts.idx_last)
                        begin
                            state_next = ST_TBL_END;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                            state_next  = ST_TBL_RD;
                        end
                    end
                end
                else if (sts.idx_last)
                begin
                    state_next = ST_TBL_END;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_TBL_RD;
                end
            end
            ST_TBL_END:
            begin
                if (sts.out_free)
                begin
                    cmd.tbl_end = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_ACK_RD:
            begin
                cmd.ack_rd = 1'b1;
                state_next = ST_ACK_OUT;
            end
            ST_ACK_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.ack_pop = 1'b1;
                    state_next  = sts.rem_one ? ST_IDLE : ST_ACK_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/rdt_datapath.sv
`timescale 1ns / 1ps
// rdt_datapath: delivery table, ack queue, counters and output register.
// Depends on rdt_pkg; commanded by rdt_ctrl.
module rdt_datapath #(
    parameter int TABLE_DEPTH = rdt_pkg::TABLE_DEPTH_DEF,
    parameter int ACK_DEPTH   = rdt_pkg::ACK_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [2:0]                      in_kind,
    input  logic [rdt_pkg::SEQ_W-1:0]       in_seq,
    input  logic [rdt_pkg::TIME_W-1:0]      in_now,
    input  logic                            cfg_wr_en,
    input  logic [rdt_pkg::TIMEOUT_W-1:0]   cfg_wr_data,
    input  rdt_pkg::cmd_t                   cmd,
    output rdt_pkg::status_t                sts,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [3:0]                      out_event,
    output logic [rdt_pkg::SEQ_W-1:0]       out_seq,
    output logic                            out_last
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int APTR_W = (ACK_DEPTH > 1) ? $clog2(ACK_DEPTH) : 1;
    localparam int ACNT_W = $clog2(ACK_DEPTH + 1);
    localparam int HIT_W  = rdt_pkg::HIT_W;
    localparam int SEQ_W  = rdt_pkg::SEQ_W;
    localparam int TIME_W = rdt_pkg::TIME_W;
    localparam int ENT_W  = SEQ_W + TIME_W;

    // memories: entry {sent time, seq}, and the ack queue as a ring
    logic [ENT_W-1:0] tbl_mem [TABLE_DEPTH];
    logic [SEQ_W-1:0] ack_mem [ACK_DEPTH];
    logic [ENT_W-1:0] tbl_rd_reg;
    logic [SEQ_W-1:0] ack_rd_reg;

    logic [TABLE_DEPTH-1:0]      valid_reg, valid_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [SEQ_W-1:0]            next_out_reg, next_out_next;
    logic [SEQ_W-1:0]            next_exp_reg, next_exp_next;
    logic [APTR_W-1:0]           ack_head_reg, ack_head_next;
    logic [ACNT_W-1:0]           ack_count_reg, ack_count_next;
    logic [HIT_W-1:0]            rem_reg, rem_next;
    logic [HIT_W-1:0]            nhit_reg, nhit_next;
    logic                        pend_valid_reg, pend_valid_next;
    rdt_pkg::event_t             pend_event_reg, pend_event_next;
    logic [SEQ_W-1:0]            pend_seq_reg, pend_seq_next;
    rdt_pkg::kind_t              kind_reg;
    logic [SEQ_W-1:0]            seq_reg;
    logic [TIME_W-1:0]           now_reg;
    logic [rdt_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic                        out_valid_reg, out_valid_next;
    rdt_pkg::event_t             out_event_reg, out_event_next;
    logic [SEQ_W-1:0]            out_seq_reg, out_seq_next;
    logic                        out_last_reg, out_last_next;

    logic                        push;
    logic                        out_free;
    logic                        tbl_we;
    logic                        ack_we;
    logic [APTR_W-1:0]           ack_tail;
    logic [ACNT_W:0]             tail_sum;
    logic [APTR_W-1:0]           head_inc;
    logic [TIME_W-1:0]           age;
    logic                        hit;
    logic [HIT_W-1:0]            rem_load;

    assign out_free = !out_valid_reg || out_ready;
    assign age      = now_reg - tbl_rd_reg[ENT_W-1:SEQ_W];
    assign hit      = (kind_reg == rdt_pkg::KIND_ACK) ? (tbl_rd_reg[SEQ_W-1:0] == seq_reg)
                                                      : (age >= TIME_W'(timeout_reg));

    assign tail_sum = (ACNT_W+1)'(ack_head_reg) + (ACNT_W+1)'(ack_count_reg);
    assign ack_tail = (tail_sum >= (ACNT_W+1)'(ACK_DEPTH))
                      ? APTR_W'(tail_sum - (ACNT_W+1)'(ACK_DEPTH)) : APTR_W'(tail_sum);
    assign head_inc = (ack_head_reg == APTR_W'(ACK_DEPTH - 1)) ? '0 : ack_head_reg + 1'b1;
    assign rem_load = (int'(ack_count_reg) > rdt_pkg::MAX_RESULTS)
                      ? HIT_W'(rdt_pkg::MAX_RESULTS) : HIT_W'(ack_count_reg);

    always_comb
    begin
        sts.kind       = kind_reg;
        sts.cur_valid  = valid_reg[idx_reg];
        sts.idx_last   = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
        sts.hit        = hit;
        sts.hit_last   = (nhit_reg == HIT_W'(rdt_pkg::MAX_RESULTS - 1));
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
        sts.rem_zero   = (rem_reg == '0);
        sts.rem_one    = (rem_reg == HIT_W'(1));
    end

    always_comb
    begin
        valid_next      = valid_reg;
        idx_next        = idx_reg;
        next_out_next   = next_out_reg;
        next_exp_next   = next_exp_reg;
        ack_head_next   = ack_head_reg;
        ack_count_next  = ack_count_reg;
        rem_next        = rem_reg;
        nhit_next       = nhit_reg;
        pend_valid_next = pend_valid_reg;
        pend_event_next = pend_event_reg;
        pend_seq_next   = pend_seq_reg;
        push            = 1'b0;
        out_event_next  = rdt_pkg::EV_NOTHING;
        out_seq_next    = '0;
        out_last_next   = 1'b1;
        tbl_we          = 1'b0;
        ack_we          = 1'b0;

        if (cmd.load)
        begin
            idx_next        = '0;
            nhit_next       = '0;
            pend_valid_next = 1'b0;
            rem_next        = rem_load;
        end

        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (cmd.single)
        begin
            push = 1'b1;
            case (kind_reg)
                rdt_pkg::KIND_SEND:
                begin
                    out_seq_next = next_out_reg;
                    if (!valid_reg[idx_reg])
                    begin
                        tbl_we              = 1'b1;
                        valid_next[idx_reg] = 1'b1;
                        next_out_next       = next_out_reg + 1'b1;
                        out_event_next      = rdt_pkg::EV_SENT;
                    end
                    else
                    begin
                        out_event_next = rdt_pkg::EV_TABLE_FULL;
                    end
                end
                rdt_pkg::KIND_RECV:
                begin
                    out_seq_next = seq_reg;
                    if (seq_reg >= next_exp_reg)
                    begin
                        next_exp_next = seq_reg + 1'b1;
                        if (ack_count_reg < ACNT_W'(ACK_DEPTH))
                        begin
                            ack_we         = 1'b1;
                            ack_count_next = ack_count_reg + 1'b1;
                            out_event_next = rdt_pkg::EV_ACCEPTED;
                        end
                        else
                        begin
                            out_event_next = rdt_pkg::EV_ACCEPTED_FULL;
                        end
                    end
                    else
                    begin
                        out_event_next = rdt_pkg::EV_REJECTED;
                    end
                end
                rdt_pkg::KIND_CLEAR:
                begin
                    valid_next     = '0;
                    next_out_next  = '0;
                    next_exp_next  = '0;
                    ack_head_next  = '0;
                    ack_count_next = '0;
                    out_event_next = rdt_pkg::EV_CLEARED;
                end
                default:
                begin
                    out_event_next = rdt_pkg::EV_NOTHING;
                end
            endcase
        end

        if (cmd.hit_take)
        begin
            valid_next[idx_reg] = 1'b0;
            nhit_next           = nhit_reg + 1'b1;
            // move the older pending result out; the newest stays back
            if (pend_valid_reg)
            begin
                push           = 1'b1;
                out_event_next = pend_event_reg;
                out_seq_next   = pend_seq_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_event_next = (kind_reg == rdt_pkg::KIND_ACK) ? rdt_pkg::EV_DELIVERED
                                                              : rdt_pkg::EV_TIMED_OUT;
            pend_seq_next   = tbl_rd_reg[SEQ_W-1:0];
        end

        if (cmd.tbl_end)
        begin
            push            = 1'b1;
            pend_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                out_event_next = pend_event_reg;
                out_seq_next   = pend_seq_reg;
            end
        end

        if (cmd.ack_pop)
        begin
            push           = 1'b1;
            out_event_next = rdt_pkg::EV_ACK_OUT;
            out_seq_next   = ack_rd_reg;
            out_last_next  = (rem_reg == HIT_W'(1));
            ack_head_next  = head_inc;
            ack_count_next = ack_count_reg - 1'b1;
            rem_next       = rem_reg - 1'b1;
        end

        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            idx_reg        <= '0;
            next_out_reg   <= '0;
            next_exp_reg   <= '0;
            ack_head_reg   <= '0;
            ack_count_reg  <= '0;
            rem_reg        <= '0;
            nhit_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            timeout_reg    <= rdt_pkg::TIMEOUT_RESET;
        end
        else
        begin
            valid_reg      <= valid_next;
            idx_reg        <= idx_next;
            next_out_reg   <= next_out_next;
            next_exp_reg   <= next_exp_next;
            ack_head_reg   <= ack_head_next;
            ack_count_reg  <= ack_count_next;
            rem_reg        <= rem_next;
            nhit_reg       <= nhit_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_event_reg <= pend_event_next;
        pend_seq_reg   <= pend_seq_next;
        if (cmd.load)
        begin
            kind_reg <= rdt_pkg::kind_t'(in_kind);
            seq_reg  <= in_seq;
            now_reg  <= in_now;
        end
        if (push)
        begin
            out_event_reg <= out_event_next;
            out_seq_reg   <= out_seq_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[idx_reg] <= {now_reg, next_out_reg};
        end
        if (cmd.tbl_rd)
        begin
            tbl_rd_reg <= tbl_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ack_we)
        begin
            ack_mem[ack_tail] <= seq_reg;
        end
        if (cmd.ack_rd)
        begin
            ack_rd_reg <= ack_mem[ack_head_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_event = out_event_reg;
    assign out_seq   = out_seq_reg;
    assign out_last  = out_last_reg;

    a_ack_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ack_count_reg <= ACNT_W'(ACK_DEPTH))
        else $error("ack count above queue depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ack_head_reg <= APTR_W'(ACK_DEPTH - 1))
        else $error("ack head outside queue");

    a_hit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nhit_reg <= HIT_W'(rdt_pkg::MAX_RESULTS))
        else $error("more results than allowed for one item");

    a_pend_kind: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (kind_reg == rdt_pkg::KIND_ACK || kind_reg == rdt_pkg::KIND_SCAN))
        else $error("pending result outside a table walk");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !push)
        else $error("result pushed over an unsent one");

endmodule

FILE: rtl/core/reliable_delivery_tracker.sv
`timescale 1ns / 1ps
// Receive, clear and unused kinds go from dispatch to a single result; send first steps
// over each occupied slot (up to TABLE_DEPTH - 1) to the lowest free one. Ack and scan walk
// the table, reading each occupied slot through a registered table read; a flush sends its
// acks one by one through a registered queue read. One item in work at a time; a new item
// is accepted while the last result still waits in the output register.
// Reset (rst_n, asynchronous) empties table and ack queue at once and sets the timeout to 1000.
module reliable_delivery_tracker #(
    parameter int TABLE_DEPTH = rdt_pkg::TABLE_DEPTH_DEF,
    parameter int ACK_DEPTH   = rdt_pkg::ACK_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,     // [31:0] seq_number, [63:32] now
    input  logic [2:0]                    s_tuser,     // [2:0] kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,     // [31:0] seq_number_res
    output logic [3:0]                    m_tuser,     // [3:0] event_res
    output logic                          m_tlast,
    input  logic                          cfg_wr_en,
    input  logic [rdt_pkg::TIMEOUT_W-1:0] cfg_wr_data  // timeout_ms
);

    rdt_pkg::cmd_t    cmd;
    rdt_pkg::status_t sts;

    rdt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rdt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ACK_DEPTH   (ACK_DEPTH)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_kind     (s_tuser),
        .in_seq      (s_tdata[31:0]),
        .in_now      (s_tdata[63:32]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_event   (m_tuser),
        .out_seq     (m_tdata),
        .out_last    (m_tlast)
    );

endmodule
